### rtl/sdtq_pkg.sv
// ----------------------------------------------------------------------------
// sdtq_pkg
// Shared types, field widths and codes for the sorted deadline timer queue.
// ----------------------------------------------------------------------------
package sdtq_pkg;

   localparam int TIMER_SLOTS_DEF = 16;
   localparam int TIMER_IDS       = 16;
   localparam int KIND_W          = 2;
   localparam int ID_W            = 4;
   localparam int DELAY_W         = 32;
   localparam int DL_W            = 48;
   localparam int TICKS_W         = 10;
   localparam int STATUS_W        = 3;
   localparam int PROD_W          = DELAY_W + TICKS_W;
   localparam int SUM_W           = DL_W + 1;

   localparam logic [TICKS_W-1:0] TICKS_RESET = TICKS_W'(1);

   // request kinds
   localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DEL   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd3;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ALREADY     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_QUEUED  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FIRED       = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTHING_DUE = 3'd4;
   localparam logic [STATUS_W-1:0] ST_QUERY       = 3'd5;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [ID_W-1:0]    timer_id;
      logic [DELAY_W-1:0] delay_ms;
      logic [DL_W-1:0]    now_tick;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     fired_timer_id;
      logic                was_fired;
      logic                last;
   } rsp_type;

   typedef enum logic [2:0] {
      PTR_HOLD     = 3'd0,
      PTR_CLEAR    = 3'd1,
      PTR_LOAD_CNT = 3'd2,
      PTR_INC      = 3'd3,
      PTR_DEC      = 3'd4
   } ptr_op_type;

   typedef enum logic [1:0] {
      RA_PTR    = 2'd0,
      RA_PTR_M1 = 2'd1,
      RA_PTR_N  = 2'd2
   } rd_sel_type;

   typedef enum logic {
      WA_PTR    = 1'b0,
      WA_PTR_M1 = 1'b1
   } wa_sel_type;

   typedef enum logic {
      WD_READ = 1'b0,
      WD_NEW  = 1'b1
   } wd_sel_type;

   typedef struct packed {
      logic                load;
      ptr_op_type          ptr_op;
      logic                rd_en;
      rd_sel_type          rd_sel;
      logic                wr_en;
      wa_sel_type          wr_addr_sel;
      wd_sel_type          wr_data_sel;
      logic                set_flag;
      logic                clr_flag_id;
      logic                clr_flag_rd;
      logic                cnt_inc;
      logic                cnt_dec;
      logic                cnt_sub_n;
      logic                found_set;
      logic                found_clr;
      logic                pend_set;
      logic                pend_clr;
      logic                nfire_load;
      logic                emit;
      logic [STATUS_W-1:0] emit_status;
      logic                emit_last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              id_queued;
      logic              full;
      logic              ptr_zero;
      logic              ptr_at_cnt;
      logic              rd_ge;
      logic              rd_due;
      logic              rd_match;
      logic              found;
      logic              pend;
      logic              compact_done;
      logic              out_free;
   } dp_status_type;

endpackage

### rtl/sdtq_datapath.sv
// ----------------------------------------------------------------------------
// sdtq_datapath
// Sorted queue storage, deadline arithmetic, counters and response register.
// ----------------------------------------------------------------------------
module sdtq_datapath #(
   parameter int TIMER_SLOTS = sdtq_pkg::TIMER_SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sdtq_pkg::req_type             req_data,
   input  logic                          csr_write,
   input  logic [sdtq_pkg::TICKS_W-1:0]  csr_data,
   input  sdtq_pkg::ctrl_cmd_type        cmd,
   output sdtq_pkg::dp_status_type       status,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output sdtq_pkg::rsp_type             rsp_data
);
   import sdtq_pkg::*;

   localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CW     = SLOT_W + 1;
   localparam int CAP    = (TIMER_SLOTS < TIMER_IDS) ? TIMER_SLOTS : TIMER_IDS;

   logic [KIND_W-1:0]    kind_ff;
   logic [ID_W-1:0]      id_ff;
   logic [DELAY_W-1:0]   delay_ff;
   logic [DL_W-1:0]      now_ff;
   logic [TICKS_W-1:0]   ticks_ff;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [SUM_W-1:0]     sum_in;
   logic [DL_W-1:0]      dl_ff, dl_in;
   logic [CW-1:0]        ptr_ff, ptr_in, ptr_m1, ptr_n;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [CW-1:0]        nfire_ff;
   logic [TIMER_IDS-1:0] flags_ff, flags_in;
   logic                 found_ff, pend_ff;
   logic [ID_W-1:0]      pend_own_ff;
   logic [DL_W-1:0]      rd_dl_ff;
   logic [ID_W-1:0]      rd_own_ff;
   logic [SLOT_W-1:0]    rd_addr, wr_addr;
   logic [DL_W-1:0]      wr_dl;
   logic [ID_W-1:0]      wr_own;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff, rsp_in;
   logic                 out_free;

   logic [DL_W-1:0]      dl_mem  [TIMER_SLOTS];
   logic [ID_W-1:0]      own_mem [TIMER_SLOTS];

   // deadline: one multiply stage, then saturating add
   assign prod_in = PROD_W'(delay_ff) * PROD_W'(ticks_ff);
   assign sum_in  = {1'b0, now_ff} + SUM_W'(prod_ff);
   assign dl_in   = sum_in[DL_W] ? {DL_W{1'b1}} : sum_in[DL_W-1:0];

   assign ptr_m1 = ptr_ff - CW'(1);
   assign ptr_n  = ptr_ff + nfire_ff;

   always_comb begin
      case (cmd.rd_sel)
         RA_PTR:    rd_addr = ptr_ff[SLOT_W-1:0];
         RA_PTR_M1: rd_addr = ptr_m1[SLOT_W-1:0];
         RA_PTR_N:  rd_addr = ptr_n[SLOT_W-1:0];
         default:   rd_addr = ptr_ff[SLOT_W-1:0];
      endcase
      wr_addr = (cmd.wr_addr_sel == WA_PTR_M1) ? ptr_m1[SLOT_W-1:0] : ptr_ff[SLOT_W-1:0];
      if (cmd.wr_data_sel == WD_NEW) begin
         wr_dl  = dl_ff;
         wr_own = id_ff;
      end else begin
         wr_dl  = rd_dl_ff;
         wr_own = rd_own_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         dl_mem[wr_addr]  <= wr_dl;
         own_mem[wr_addr] <= wr_own;
      end
      if (cmd.rd_en) begin
         rd_dl_ff  <= dl_mem[rd_addr];
         rd_own_ff <= own_mem[rd_addr];
      end
   end

   always_comb begin
      case (cmd.ptr_op)
         PTR_HOLD:     ptr_in = ptr_ff;
         PTR_CLEAR:    ptr_in = '0;
         PTR_LOAD_CNT: ptr_in = cnt_ff;
         PTR_INC:      ptr_in = ptr_ff + CW'(1);
         PTR_DEC:      ptr_in = ptr_m1;
         default:      ptr_in = ptr_ff;
      endcase

      cnt_in = cnt_ff;
      if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         cnt_in = cnt_ff - CW'(1);
      end else if (cmd.cnt_sub_n) begin
         cnt_in = cnt_ff - nfire_ff;
      end

      flags_in = flags_ff;
      if (cmd.set_flag) begin
         flags_in[id_ff] = 1'b1;
      end
      if (cmd.clr_flag_id) begin
         flags_in[id_ff] = 1'b0;
      end
      if (cmd.clr_flag_rd) begin
         flags_in[rd_own_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      dl_ff   <= dl_in;
      ptr_ff  <= ptr_in;
      if (cmd.load) begin
         kind_ff  <= req_data.kind;
         id_ff    <= req_data.timer_id;
         delay_ff <= req_data.delay_ms;
         now_ff   <= req_data.now_tick;
      end
      if (cmd.nfire_load) begin
         nfire_ff <= ptr_ff;
      end
      if (cmd.pend_set) begin
         pend_own_ff <= rd_own_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= TICKS_RESET;
         cnt_ff   <= '0;
         flags_ff <= '0;
         found_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            ticks_ff <= csr_data;
         end
         cnt_ff   <= cnt_in;
         flags_ff <= flags_in;
         if (cmd.found_clr) begin
            found_ff <= 1'b0;
         end else if (cmd.found_set) begin
            found_ff <= 1'b1;
         end
         if (cmd.pend_clr) begin
            pend_ff <= 1'b0;
         end else if (cmd.pend_set) begin
            pend_ff <= 1'b1;
         end
      end
   end

   // response register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_in.status         = cmd.emit_status;
      rsp_in.fired_timer_id = (cmd.emit_status == ST_FIRED) ? pend_own_ff : '0;
      rsp_in.was_fired      = (cmd.emit_status == ST_QUERY) ? !flags_ff[id_ff] : 1'b0;
      rsp_in.last           = cmd.emit_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      status.kind         = kind_ff;
      status.id_queued    = flags_ff[id_ff];
      status.full         = (cnt_ff >= CW'(CAP));
      status.ptr_zero     = (ptr_ff == '0);
      status.ptr_at_cnt   = (ptr_ff == cnt_ff);
      status.rd_ge        = (rd_dl_ff >= dl_ff);
      status.rd_due       = (rd_dl_ff <= now_ff);
      status.rd_match     = (rd_own_ff == id_ff);
      status.found        = found_ff;
      status.pend         = pend_ff;
      status.compact_done = (ptr_n == cnt_ff);
      status.out_free     = out_free;
   end

endmodule

### rtl/sdtq_ctrl.sv
// ----------------------------------------------------------------------------
// sdtq_ctrl
// Sequencer that walks the sorted queue one entry at a time, reading each entry before comparing or writing it.
// ----------------------------------------------------------------------------
module sdtq_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  sdtq_pkg::dp_status_type  status,
   output sdtq_pkg::ctrl_cmd_type   cmd
);
   import sdtq_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE     = 13'b0000000000001,
      S_DISPATCH = 13'b0000000000010,
      S_ADD_WAIT = 13'b0000000000100,
      S_ADD_RD   = 13'b0000000001000,
      S_ADD_CMP  = 13'b0000000010000,
      S_DEL_RD   = 13'b0000000100000,
      S_DEL_CMP  = 13'b0000001000000,
      S_TICK_RD  = 13'b0000010000000,
      S_TICK_CMP = 13'b0000100000000,
      S_TICK_END = 13'b0001000000000,
      S_CMP_RD   = 13'b0010000000000,
      S_CMP_WR   = 13'b0100000000000,
      S_REPLY    = 13'b1000000000000
   } state_type;

   state_type           state_ff, state_in;
   logic [STATUS_W-1:0] st_ff, st_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      st_in     = st_ff;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (status.kind)
               KIND_ADD: begin
                  if (status.id_queued || status.full) begin
                     st_in    = ST_ALREADY;
                     state_in = S_REPLY;
                  end else begin
                     cmd.ptr_op = PTR_LOAD_CNT;
                     state_in   = S_ADD_WAIT;
                  end
               end
               KIND_DEL: begin
                  if (!status.id_queued) begin
                     st_in    = ST_NOT_QUEUED;
                     state_in = S_REPLY;
                  end else begin
                     cmd.ptr_op    = PTR_CLEAR;
                     cmd.found_clr = 1'b1;
                     state_in      = S_DEL_RD;
                  end
               end
               KIND_TICK: begin
                  cmd.ptr_op   = PTR_CLEAR;
                  cmd.pend_clr = 1'b1;
                  state_in     = S_TICK_RD;
               end
               default: begin
                  st_in    = ST_QUERY;
                  state_in = S_REPLY;
               end
            endcase
         end
         // deadline product and sum settle here
         S_ADD_WAIT: begin
            state_in = S_ADD_RD;
         end
         S_ADD_RD: begin
            if (status.ptr_zero) begin
               cmd.wr_en       = 1'b1;
               cmd.wr_addr_sel = WA_PTR;
               cmd.wr_data_sel = WD_NEW;
               cmd.set_flag    = 1'b1;
               cmd.cnt_inc     = 1'b1;
               st_in           = ST_OK;
               state_in        = S_REPLY;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RA_PTR_M1;
               state_in   = S_ADD_CMP;
            end
         end
         S_ADD_CMP: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_addr_sel = WA_PTR;
            if (status.rd_ge) begin
               // shift the later entry up one position
               cmd.wr_data_sel = WD_READ;
               cmd.ptr_op      = PTR_DEC;
               state_in        = S_ADD_RD;
            end else begin
               cmd.wr_data_sel = WD_NEW;
               cmd.set_flag    = 1'b1;
               cmd.cnt_inc     = 1'b1;
               st_in           = ST_OK;
               state_in        = S_REPLY;
            end
         end
         S_DEL_RD: begin
            if (status.ptr_at_cnt) begin
               cmd.clr_flag_id = 1'b1;
               cmd.cnt_dec     = 1'b1;
               st_in           = ST_OK;
               state_in        = S_REPLY;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RA_PTR;
               state_in   = S_DEL_CMP;
            end
         end
         S_DEL_CMP: begin
            if (status.found) begin
               cmd.wr_en       = 1'b1;
               cmd.wr_addr_sel = WA_PTR_M1;
               cmd.wr_data_sel = WD_READ;
            end
            if (status.rd_match) begin
               cmd.found_set = 1'b1;
            end
            cmd.ptr_op = PTR_INC;
            state_in   = S_DEL_RD;
         end
         S_TICK_RD: begin
            if (status.ptr_at_cnt) begin
               state_in = S_TICK_END;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RA_PTR;
               state_in   = S_TICK_CMP;
            end
         end
         S_TICK_CMP: begin
            // the previous expiry goes out once the next one is known to be due
            if (!status.rd_due) begin
               state_in = S_TICK_END;
            end else if (!status.pend || status.out_free) begin
               if (status.pend) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = ST_FIRED;
                  cmd.emit_last   = 1'b0;
               end
               cmd.pend_set    = 1'b1;
               cmd.clr_flag_rd = 1'b1;
               cmd.ptr_op      = PTR_INC;
               state_in        = S_TICK_RD;
            end
         end
         S_TICK_END: begin
            if (status.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_last   = 1'b1;
               cmd.emit_status = status.pend ? ST_FIRED : ST_NOTHING_DUE;
               cmd.nfire_load  = 1'b1;
               cmd.ptr_op      = PTR_CLEAR;
               state_in        = status.pend ? S_CMP_RD : S_IDLE;
            end
         end
         S_CMP_RD: begin
            if (status.compact_done) begin
               cmd.cnt_sub_n = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RA_PTR_N;
               state_in   = S_CMP_WR;
            end
         end
         S_CMP_WR: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_addr_sel = WA_PTR;
            cmd.wr_data_sel = WD_READ;
            cmd.ptr_op      = PTR_INC;
            state_in        = S_CMP_RD;
         end
         S_REPLY: begin
            if (status.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = st_ff;
               cmd.emit_last   = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         st_ff    <= ST_OK;
      end else begin
         state_ff <= state_in;
         st_ff    <= st_in;
      end
   end

endmodule

### rtl/sorted_deadline_timer_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue_unit
// Deadline-sorted timer queue with add, delete, tick expiry and query.
// ----------------------------------------------------------------------------
// Usage:
//  - req_valid/req_stall/req_data carry one command transaction (add, delete,
//    tick or query). req_stall is low only while the sequencer is idle, so
//    one command is in work at a time.
//  - rsp_valid/rsp_stall/rsp_data return results. Add, delete and query give
//    one result; a tick gives one result per expired timer, soonest first,
//    or a single "nothing due" result, with last set on the final one.
//  - csr_valid/csr_ready/csr_data write ticks_per_ms; csr_ready is always high.
//  - An add, delete or tick walks the entry memory one entry at a time, with
//    a registered read, then a compare and, where needed, a write for each
//    entry; query and refused commands skip the walk. After expiries the
//    remaining entries move down in a further pass. The next command is
//    taken once the sequencer is back in idle.
//  - A result waits in the output register while rsp_stall is high; the next
//    command is still taken, and its first result waits for the register.
//  - Reset empties the queue and sets ticks_per_ms to 1; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_deadline_timer_queue_unit #(
   parameter int TIMER_SLOTS = sdtq_pkg::TIMER_SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  sdtq_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output sdtq_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sdtq_pkg::TICKS_W-1:0]  csr_data
);
   import sdtq_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   sdtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sdtq_datapath #(
      .TIMER_SLOTS (TIMER_SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/sdtq_checker.sv
// ----------------------------------------------------------------------------
// sdtq_checker
// Port-level checks for the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module sdtq_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input sdtq_pkg::rsp_type rsp_data
);
   import sdtq_pkg::*;

   // a held result keeps its contents
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // one command in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second command taken while busy");

   // only expiry results carry a timer id
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_FIRED |-> rsp_data.fired_timer_id == '0)
      else $error("timer id on non-expiry result");

   // every non-expiry command gives a single result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_FIRED |-> rsp_data.last)
      else $error("single result not marked last");

   // was_fired belongs to query answers only
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_QUERY |-> !rsp_data.was_fired)
      else $error("was_fired set outside a query answer");

endmodule

bind sorted_deadline_timer_queue_unit sdtq_checker u_sdtq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
